// ----- design/scoa_pkg.sv -----
// Shared constants, types and helpers of the size-class offset allocator.
`default_nettype none
package scoa_pkg;
   localparam int RegionLog2   = 16;
   localparam int MinClassLog2 = 7;
   localparam int MaxClassLog2 = 30;
   localparam int StackDepth   = 512;
   localparam int TopClass     = (RegionLog2 < MaxClassLog2 - 1) ? RegionLog2 : MaxClassLog2 - 1;
   localparam int NumClasses   = TopClass - MinClassLog2 + 1;
   localparam int ClassSlots   = StackDepth / NumClasses;
   localparam int AddrW        = $clog2(StackDepth);
   localparam int CntW         = $clog2(ClassSlots + 1);
   localparam int ClsW         = 5;
   localparam int IdxW         = $clog2(NumClasses);
   localparam int BumpW        = RegionLog2 + 1;

   typedef logic [2:0] status_type;
   localparam status_type StOk       = 3'd0;
   localparam status_type StOom      = 3'd1;
   localparam status_type StTooLarge = 3'd2;
   localparam status_type StRetired  = 3'd3;
   localparam status_type StOverflow = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_CHECK, S_POP_RD, S_POP_WAIT, S_SPLIT, S_DONE
   } state_type;

   // memory access from the controller
   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] addr;
      logic [15:0]      wdata;
   } mem_req_type;

   // rounded-up class exponent of a 17-bit size
   function automatic logic [ClsW-1:0] size_class(input logic [16:0] size);
      logic [ClsW-1:0] c;
      c = ClsW'(17);
      for (int i = 16; i >= MinClassLog2; i--)
         if (size <= (17'd1 << i)) c = ClsW'(i);
      return c;
   endfunction

   function automatic logic [AddrW-1:0] slot_addr(input logic [ClsW-1:0] c,
                                                  input logic [CntW-1:0] n);
      logic [AddrW+CntW:0] a;
      a = (AddrW+CntW+1)'(c - ClsW'(MinClassLog2)) * (AddrW+CntW+1)'(ClassSlots)
          + (AddrW+CntW+1)'(n);
      return a[AddrW-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- design/scoa_stack_mem.sv -----
// Free stack store: single-port synchronous memory with a registered read.
`default_nettype none
module scoa_stack_mem (
   input  wire                 clock,
   input  scoa_pkg::mem_req_type req,
   output logic [15:0]         rdata
);
   import scoa_pkg::*;
   logic [15:0] mem [StackDepth];
   always_ff @(posedge clock) begin
      if (req.we) mem[req.addr] <= req.wdata;
      rdata <= mem[req.addr];
   end
endmodule
`default_nettype wire

// ----- design/size_class_offset_allocator_unit.sv -----
// Top level of the size-class offset allocator: controller, counts and bump pointer.
// Usage: present an item on req_valid with req_operation (0 allocate, 1 free),
// req_request_size and req_block_offset; it is accepted when req_stall is low.
// One item is worked at a time. The result leaves on rsp_valid with
// rsp_result_offset and rsp_status and is held while rsp_stall is high.
// From the accept edge to rsp_valid: S_CHECK and S_DONE for a bump allocation,
// a free and every early error; S_CHECK, S_POP_RD, S_POP_WAIT and S_DONE for a pop
// from the request's own class; a split of class k for a request of class c walks
// S_SEARCH up to k, checks room in S_SPLIT, pops, then pushes the remainders;
// a failed search ends out of memory. Each split step is one count check or one
// stack memory access per cycle. A new item is taken in the cycle the previous
// result leaves or later.
// csr_write_enable/csr_write_data set backend_retired; the user must write it only while idle, the block has no check.
// Reset clears the bump pointer, all class counts and backend_retired;
// the stack memory needs no clearing since only counted entries are read.
`default_nettype none
module size_class_offset_allocator_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_operation,
   input  wire  [16:0] req_request_size,
   input  wire  [15:0] req_block_offset,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [15:0] rsp_result_offset,
   output logic [2:0]  rsp_status,
   input  wire         csr_write_enable,
   input  wire         csr_write_data
);
   import scoa_pkg::*;

   state_type state_ff, state_in;
   logic retired_ff;
   logic [BumpW-1:0] bump_ff, bump_in;
   logic [CntW-1:0] cnt_ff [NumClasses];
   logic op_ff, op_in;
   logic [ClsW-1:0] cls_ff, cls_in, k_ff, k_in, i_ff, i_in;
   logic [15:0] boff_ff, boff_in, base_ff, base_in;
   logic [BumpW-1:0] start_ff, start_in;
   logic rv_ff, rv_in;
   logic [15:0] ro_ff, ro_in;
   status_type rs_ff, rs_in;
   mem_req_type mreq;
   logic [15:0] rdata;
   logic cnt_we, cnt_inc;
   logic [ClsW-1:0] cnt_cls;

   scoa_stack_mem u_mem (.clock(clock), .req(mreq), .rdata(rdata));

   function automatic logic [CntW-1:0] cnt_of(input logic [ClsW-1:0] c,
                                              input logic [CntW-1:0] arr [NumClasses]);
      return arr[IdxW'(c - ClsW'(MinClassLog2))];
   endfunction

   logic [ClsW-1:0] req_cls;
   logic [BumpW:0]  bump_sum;
   logic            out_free;
   logic [BumpW-1:0] csize;
   assign req_cls  = size_class(req_request_size);
   assign csize    = BumpW'(1) << cls_ff;
   assign bump_sum = {1'b0, bump_ff} + {1'b0, csize};
   assign out_free = !rv_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && out_free);

   always_comb begin
      logic [BumpW-1:0] end_v;
      state_in = state_ff; bump_in = bump_ff; op_in = op_ff; cls_in = cls_ff;
      k_in = k_ff; i_in = i_ff; boff_in = boff_ff; base_in = base_ff;
      start_in = start_ff; rv_in = rv_ff && rsp_stall; ro_in = ro_ff; rs_in = rs_ff;
      mreq = '{we: 1'b0, addr: '0, wdata: '0};
      cnt_we = 1'b0; cnt_inc = 1'b0; cnt_cls = cls_ff;
      end_v = BumpW'(base_ff) + (BumpW'(1) << k_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid && out_free) begin
               op_in = req_operation; cls_in = req_cls; boff_in = req_block_offset;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // decide between bump, stack, split and error paths
            state_in = S_DONE; rs_in = StOk; ro_in = '0;
            if (cls_ff < ClsW'(MinClassLog2) || cls_ff > ClsW'(TopClass)) begin
               rs_in = StTooLarge;
            end else if (!op_ff) begin
               if (bump_sum <= (BumpW+1)'(1) << RegionLog2) begin
                  ro_in = bump_ff[15:0]; bump_in = bump_sum[BumpW-1:0];
               end else if (retired_ff) begin
                  rs_in = StRetired;
               end else if (cnt_of(cls_ff, cnt_ff) != '0) begin
                  k_in = cls_ff; state_in = S_POP_RD;
               end else begin
                  k_in = cls_ff + ClsW'(1); state_in = S_SEARCH;
               end
            end else begin
               if (BumpW'(boff_ff) + csize == bump_ff) begin
                  bump_in = BumpW'(boff_ff);
               end else if (retired_ff) begin
                  rs_in = StRetired;
               end else if (cnt_of(cls_ff, cnt_ff) >= CntW'(ClassSlots)) begin
                  rs_in = StOverflow;
               end else begin
                  mreq = '{we: 1'b1, addr: slot_addr(cls_ff, cnt_of(cls_ff, cnt_ff)),
                           wdata: boff_ff};
                  cnt_we = 1'b1; cnt_inc = 1'b1;
               end
            end
         end
         S_SEARCH: begin
            // walk up one class per cycle; then check remainder room
            if (k_ff > ClsW'(TopClass)) begin
               rs_in = StOom; ro_in = '0; state_in = S_DONE;
            end else if (cnt_of(k_ff, cnt_ff) != '0) begin
               i_in = cls_ff; state_in = S_SPLIT; start_in = '0;
               // reuse S_SPLIT with start=0 as the room check phase
            end else begin
               k_in = k_ff + ClsW'(1);
            end
         end
         S_SPLIT: begin
            if (start_ff == '0) begin
               if (cnt_of(i_ff, cnt_ff) >= CntW'(ClassSlots)) begin
                  rs_in = StOverflow; ro_in = '0; state_in = S_DONE;
               end else if (i_ff + ClsW'(1) >= k_ff) begin
                  state_in = S_POP_RD;
               end else begin
                  i_in = i_ff + ClsW'(1);
               end
            end else begin
               // push remainders from class k-1 downward
               if (start_ff < end_v && i_ff >= cls_ff) begin
                  mreq = '{we: 1'b1, addr: slot_addr(i_ff, cnt_of(i_ff, cnt_ff)),
                           wdata: start_ff[15:0]};
                  cnt_we = 1'b1; cnt_inc = 1'b1; cnt_cls = i_ff;
                  start_in = start_ff + (BumpW'(1) << i_ff);
                  i_in = i_ff - ClsW'(1);
               end else begin
                  rs_in = StOk; ro_in = base_ff; state_in = S_DONE;
               end
            end
         end
         S_POP_RD: begin
            mreq.addr = slot_addr(k_ff, cnt_of(k_ff, cnt_ff) - CntW'(1));
            cnt_we = 1'b1; cnt_cls = k_ff;
            state_in = S_POP_WAIT;
         end
         S_POP_WAIT: begin
            base_in = rdata;
            if (k_ff == cls_ff) begin
               rs_in = StOk; ro_in = rdata; state_in = S_DONE;
            end else begin
               start_in = BumpW'(rdata) + csize; i_in = k_ff - ClsW'(1);
               state_in = S_SPLIT;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; retired_ff <= 1'b0; bump_ff <= '0; rv_ff <= 1'b0;
         for (int n = 0; n < NumClasses; n++) cnt_ff[n] <= '0;
      end else begin
         state_ff <= state_in; bump_ff <= bump_in; rv_ff <= rv_in;
         if (csr_write_enable) retired_ff <= csr_write_data;
         if (cnt_we) begin
            if (cnt_inc) cnt_ff[IdxW'(cnt_cls - ClsW'(MinClassLog2))] <=
                            cnt_of(cnt_cls, cnt_ff) + CntW'(1);
            else cnt_ff[IdxW'(cnt_cls - ClsW'(MinClassLog2))] <=
                    cnt_of(cnt_cls, cnt_ff) - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; cls_ff <= cls_in; k_ff <= k_in; i_ff <= i_in;
      boff_ff <= boff_in; base_ff <= base_in; start_ff <= start_in;
      ro_ff <= ro_in; rs_ff <= rs_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_result_offset = ro_ff;
   assign rsp_status = rs_ff;
endmodule
`default_nettype wire

// ----- dv/scoa_checker.sv -----
// Checker for the size-class offset allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module scoa_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire         req_operation,
   input  wire  [16:0] req_request_size,
   input  wire  [15:0] req_block_offset,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [15:0] rsp_result_offset,
   input  wire  [2:0]  rsp_status,
   input  wire         csr_write_enable,
   input  wire         csr_write_data,
   output int          error_count,
   output int          pending_count
);
   import scoa_pkg::*;

   typedef struct {
      logic [15:0] offset;
      status_type  status;
   } alloc_result_type;

   localparam int OpAlloc = 0;

   logic        retired;
   logic [16:0] bump;
   logic [15:0] slot_mem [StackDepth];
   int          class_fill [32];
   alloc_result_type expected_q [$];

   function automatic int round_class(input logic [16:0] size);
      int c;
      c = MinClassLog2;
      while ((64'd1 << c) < size) c++;
      return c;
   endfunction

   function automatic int slot_index(input int c, input int n);
      return (c - MinClassLog2) * ClassSlots + n;
   endfunction

   task automatic push_free(input int c, input logic [16:0] off);
      slot_mem[slot_index(c, class_fill[c])] = off[15:0];
      class_fill[c]++;
   endtask

   task automatic pop_free(input int c, output logic [16:0] off);
      class_fill[c]--;
      off = {1'b0, slot_mem[slot_index(c, class_fill[c])]};
   endtask

   task automatic predict_item(input logic op, input logic [16:0] size,
                               input logic [15:0] boff, output alloc_result_type r);
      int c, k, i;
      logic [16:0] base, start, blk_end;
      logic [17:0] sum;
      c = round_class(size);
      r.offset = '0;
      r.status = StOk;
      if (c > TopClass) begin
         r.status = StTooLarge;
         return;
      end
      if (op == OpAlloc) begin
         sum = {1'b0, bump} + (18'd1 << c);
         if (sum <= (18'd1 << RegionLog2)) begin
            r.offset = bump[15:0];
            bump = sum[16:0];
         end else if (retired) begin
            r.status = StRetired;
         end else if (class_fill[c] != 0) begin
            pop_free(c, base);
            r.offset = base[15:0];
         end else begin
            k = c + 1;
            while (k <= TopClass && class_fill[k] == 0) k++;
            if (k > TopClass) begin
               r.status = StOom;
               return;
            end
            for (i = c; i < k; i++)
               if (class_fill[i] >= ClassSlots) r.status = StOverflow;
            if (r.status != StOk) return;
            pop_free(k, base);
            blk_end = base + (17'd1 << k);
            start = base + (17'd1 << c);
            for (i = k - 1; start < blk_end && i >= c; i--) begin
               push_free(i, start);
               start = start + (17'd1 << i);
            end
            r.offset = base[15:0];
         end
      end else begin
         sum = {2'b0, boff} + (18'd1 << c);
         if (sum == {1'b0, bump}) begin
            bump = {1'b0, boff};
         end else if (retired) begin
            r.status = StRetired;
         end else if (class_fill[c] >= ClassSlots) begin
            r.status = StOverflow;
         end else begin
            push_free(c, {1'b0, boff});
         end
      end
   endtask

   always @(posedge clock) begin
      alloc_result_type r, e;
      if (reset) begin
         retired <= 1'b0;
         bump = '0;
         for (int i = 0; i < 32; i++) class_fill[i] = 0;
         expected_q.delete();
         error_count <= 0;
      end else begin
         if (csr_write_enable) retired <= csr_write_data;
         if (req_valid && !req_stall) begin
            predict_item(req_operation, req_request_size, req_block_offset, r);
            expected_q = {expected_q, r};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result offset=%h status=%0d", $time,
                        rsp_result_offset, rsp_status);
               error_count <= error_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e.offset !== rsp_result_offset || e.status !== rsp_status) begin
                  $display({"%0t: mismatch expected offset=%h status=%0d",
                            " actual offset=%h status=%0d"},
                           $time, e.offset, e.status, rsp_result_offset, rsp_status);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_count <= expected_q.size();
   end
endmodule

// ----- dv/tb_top.sv -----
// Top of the size-class offset allocator testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
   import scoa_pkg::*;

   localparam logic OpAlloc = 1'b0;
   localparam logic OpFree  = 1'b1;
   localparam int WatchLimit = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_operation = 1'b0;
   logic [16:0] req_request_size = '0;
   logic [15:0] req_block_offset = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   wire         req_stall, rsp_valid;
   wire  [15:0] rsp_result_offset;
   wire  [2:0]  rsp_status;
   int          error_count, pending_count;
   int          send_idle_pct = 0, stall_pct = 0;
   int          idle_cycles = 0;
   logic [15:0] live_off [$];
   logic [16:0] live_size [$];

   always #5 clock = ~clock;

   size_class_offset_allocator_unit i_dut (.*);

   scoa_checker i_checker (.*);

   // receiver stall
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("size_class_offset_allocator_unit verification failed");
         $finish;
      end
   end

   // valid stays up after an accept until the next item or an idle cycle drops it
   task automatic send_item(input logic op, input logic [16:0] size,
                            input logic [15:0] boff);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_request_size <= size;
      req_block_offset <= boff;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_and_config(input logic value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || rsp_valid) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [16:0] rand_size();
      case ($urandom_range(9))
         0: return 17'($urandom_range(65536));
         1: return 17'($urandom_range(131071));
         2, 3: return 17'($urandom_range(128));
         default: return 17'(1) << $urandom_range(7, 12) - 17'($urandom_range(1));
      endcase
   endfunction

   task automatic random_phase(input int n, input int idle, input int stall);
      logic [16:0] sz;
      logic [15:0] off;
      int j;
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 45 || live_off.size() == 0) begin
            sz = rand_size();
            off = 16'($urandom);
            send_item(OpAlloc, sz, off);
            // remember a plausible block for a later free
            live_off = {live_off, 16'($urandom) & ~16'd127};
            live_size = {live_size, sz};
         end else if ($urandom_range(9) < 7) begin
            j = $urandom_range(live_off.size() - 1);
            send_item(OpFree, live_size[j], live_off[j]);
            live_off.delete(j);
            live_size.delete(j);
         end else begin
            send_item(OpFree, rand_size(), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: fill the region, oversize requests, split, frees at the bump pointer
      send_item(OpAlloc, 17'd0, 16'hFFFF);
      send_item(OpAlloc, 17'd129, 16'd0);
      send_item(OpAlloc, 17'd131071, 16'd0);
      send_item(OpAlloc, 17'd65537, 16'd0);
      send_item(OpFree, 17'd131071, 16'd0);
      send_item(OpFree, 17'd256, 16'd128);
      send_item(OpFree, 17'd128, 16'd0);
      send_item(OpAlloc, 17'd65536, 16'd0);
      send_item(OpAlloc, 17'd1, 16'd0);
      send_item(OpFree, 17'd32768, 16'd0);
      send_item(OpAlloc, 17'd128, 16'd0);
      send_item(OpAlloc, 17'd4096, 16'd0);
      send_item(OpFree, 17'd65536, 16'd0);
      send_item(OpFree, 17'd128, 16'hFFFF);
      send_item(OpAlloc, 17'd128, 16'd0);
      send_item(OpAlloc, 17'd128, 16'd0);
      for (int i = 0; i < 6; i++) send_item(OpFree, 17'd128, 16'(i * 7));
      drain_and_config(1'b1);
      send_item(OpAlloc, 17'd128, 16'd0);
      send_item(OpFree, 17'd128, 16'h1234);
      send_item(OpFree, 17'd65536, 16'd0);
      drain_and_config(1'b0);
      random_phase(200, 0, 0);
      random_phase(150, 59, 0);
      drain_and_config(1'b1);
      random_phase(100, 0, 59);
      drain_and_config(1'b0);
      random_phase(200, 36, 36);
      random_phase(100, 0, 0);
      drain_and_config(1'b1);
      random_phase(50, 36, 36);
      drain_and_config(1'b0);
      random_phase(100, 59, 59);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || rsp_valid) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("size_class_offset_allocator_unit verification clean");
      else
         $display("size_class_offset_allocator_unit verification failed");
      $finish;
   end
endmodule

// ----- sim.f -----
design/scoa_pkg.sv
design/scoa_stack_mem.sv
design/size_class_offset_allocator_unit.sv
dv/scoa_checker.sv
dv/tb_top.sv
